@@ hdl/rmfe_pkg.sv @@
// Package for the rotary menu frequency editor.
// Holds menu codes, counter sizes, the shared-unit opcode and the sequencer types.
// No dependencies.
package rmfe_pkg;

  // Width of the frequency result
  localparam int unsigned FREQ_W = 27;

  // Menu codes (active_menu / edit target)
  localparam logic [2:0] MENU_TOP   = 3'd0;
  localparam logic [2:0] MENU_WAVE  = 3'd1;
  localparam logic [2:0] MENU_HIGH  = 3'd2;
  localparam logic [2:0] MENU_LOW   = 3'd3;
  localparam logic [2:0] MENU_SCALE = 3'd4;

  // Wrap sizes of the counters
  localparam logic [3:0] TOP_ENTRIES = 4'd4;
  localparam logic [3:0] WAVE_MOD    = 4'd3;
  localparam logic [3:0] DIGIT_MOD   = 4'd10;
  localparam logic [3:0] SCALE_MOD   = 4'd7;

  // Shared unit operations
  typedef enum logic [0:0] {
    OP_STEP  = 1'b0,  // wrap a counter one step up or down
    OP_MAC10 = 1'b1   // a * 10 + b
  } op_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_STEP  = 5'b00010,
    ST_PRESS = 5'b00100,
    ST_FREQ  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic step;        // apply one tick to the counter being edited
    logic step_down;   // tick direction: 1 decrements
    logic press;       // apply the short press to the edit target
    logic freq_load;   // seed the frequency accumulator with the high digit
    logic freq_mac;    // accumulate one decade
    logic freq_first;  // first decade also adds the low digit
    logic deliver;     // load the result register
    logic changed;     // changed flag of the current request
  } ctrl_t;

endpackage

@@ hdl/rmfe_if.sv @@
// Handshake channels of the rotary menu frequency editor.
// Request channel carries encoder events, result channel carries the menu state.
// No dependencies.
interface rmfe_in_if;
  logic              valid;
  logic              ready;
  logic              rot_flag;
  logic              press_flag;
  logic signed [7:0] step_count;

  modport source (output valid, output rot_flag, output press_flag,
                  output step_count, input ready);
  modport sink   (input valid, input rot_flag, input press_flag,
                  input step_count, output ready);
endinterface

interface rmfe_out_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic [2:0]  active_menu;
  logic [1:0]  cursor_position;
  logic [1:0]  waveform_choice;
  logic [3:0]  high_digit;
  logic [3:0]  low_digit;
  logic [2:0]  scale_exponent;
  logic [26:0] frequency_hz;

  modport source (output valid, output changed, output active_menu,
                  output cursor_position, output waveform_choice, output high_digit,
                  output low_digit, output scale_exponent, output frequency_hz,
                  input ready);
  modport sink   (input valid, input changed, input active_menu,
                  input cursor_position, input waveform_choice, input high_digit,
                  input low_digit, input scale_exponent, input frequency_hz,
                  output ready);
endinterface

@@ hdl/rotary_menu_frequency_editor_core.sv @@
// Rotary-encoder menu that edits a waveform choice and a frequency setting.
// Depends on rmfe_pkg, rmfe_if, rmfe_alu and rmfe_seq.
//
// One request is handled at a time. From the accepting edge the sequencer steps the
// counter being edited by one rotation tick per cycle (no ticks without the rotation
// flag), then applies the press and the accumulator seed, then runs scale_exponent + 1
// multiply-by-ten steps on the shared unit (scale_exponent is the value after the
// request), and then loads the result register. in_req.ready is high only while the
// sequencer is idle, so a new request is taken only after the previous one has loaded
// its result. The result register holds the finished result until it is taken, while
// the next request may already be accepted; a result that is still waiting delays
// the load of the next one.
module rotary_menu_frequency_editor_core
  import rmfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rmfe_in_if.sink     in_req,
  rmfe_out_if.source  out_res
);

  ctrl_t             ctrl;
  op_t               alu_op;
  logic [FREQ_W-1:0] alu_a, alu_y;
  logic [3:0]        alu_b, alu_mod;
  logic              out_free;

  logic [1:0]        cursor_r, cursor_nxt;
  logic [2:0]        target_r, target_nxt;
  logic [1:0]        wave_r, wave_nxt;
  logic [3:0]        tens_r, tens_nxt;
  logic [3:0]        units_r, units_nxt;
  logic [2:0]        decade_r, decade_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              o_changed_r;
  logic [2:0]        o_menu_r;
  logic [1:0]        o_cursor_r, o_wave_r;
  logic [3:0]        o_high_r, o_low_r;
  logic [2:0]        o_scale_r;
  logic [FREQ_W-1:0] o_freq_r;

  assign out_free = ~out_valid_r | out_res.ready;

  rmfe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .rot      (in_req.rot_flag),
    .press    (in_req.press_flag),
    .ticks    (in_req.step_count),
    .decade   (decade_r),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Route the edited counter or the accumulator into the shared unit
  always_comb begin
    alu_op  = ctrl.freq_mac ? OP_MAC10 : OP_STEP;
    alu_b   = ctrl.freq_first ? units_r : 4'd0;
    alu_a   = freq_r;
    alu_mod = SCALE_MOD;
    if (!ctrl.freq_mac) begin
      case (target_r)
        MENU_TOP: begin
          alu_a   = FREQ_W'(cursor_r);
          alu_mod = TOP_ENTRIES;
        end
        MENU_WAVE: begin
          alu_a   = FREQ_W'(wave_r);
          alu_mod = WAVE_MOD;
        end
        MENU_HIGH: begin
          alu_a   = FREQ_W'(tens_r);
          alu_mod = DIGIT_MOD;
        end
        MENU_LOW: begin
          alu_a   = FREQ_W'(units_r);
          alu_mod = DIGIT_MOD;
        end
        default: begin
          alu_a   = FREQ_W'(decade_r);
          alu_mod = SCALE_MOD;
        end
      endcase
    end
  end

  rmfe_alu u_alu (
    .op      (alu_op),
    .a       (alu_a),
    .b       (alu_b),
    .modulus (alu_mod),
    .down    (ctrl.step_down),
    .y       (alu_y)
  );

  // Write back ticks, press and accumulator
  always_comb begin
    cursor_nxt = cursor_r;
    target_nxt = target_r;
    wave_nxt   = wave_r;
    tens_nxt   = tens_r;
    units_nxt  = units_r;
    decade_nxt = decade_r;
    freq_nxt   = freq_r;
    if (ctrl.step) begin
      case (target_r)
        MENU_TOP:  cursor_nxt = alu_y[1:0];
        MENU_WAVE: wave_nxt   = alu_y[1:0];
        MENU_HIGH: tens_nxt   = alu_y[3:0];
        MENU_LOW:  units_nxt  = alu_y[3:0];
        default:   decade_nxt = alu_y[2:0];
      endcase
    end
    if (ctrl.press) begin
      target_nxt = (target_r == MENU_TOP) ? {1'b0, cursor_r} + 3'd1 : MENU_TOP;
    end
    if (ctrl.freq_load) begin
      freq_nxt = FREQ_W'(tens_r);
    end
    if (ctrl.freq_mac) begin
      freq_nxt = alu_y;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.deliver) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= 2'd0;
      target_r    <= MENU_TOP;
      wave_r      <= 2'd0;
      tens_r      <= 4'd1;
      units_r     <= 4'd0;
      decade_r    <= 3'd3;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      target_r    <= target_nxt;
      wave_r      <= wave_nxt;
      tens_r      <= tens_nxt;
      units_r     <= units_nxt;
      decade_r    <= decade_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result payload; a zero frequency reads as one
  always_ff @(posedge clk) begin
    freq_r <= freq_nxt;
    if (ctrl.deliver) begin
      o_changed_r <= ctrl.changed;
      o_menu_r    <= target_r;
      o_cursor_r  <= cursor_r;
      o_wave_r    <= wave_r;
      o_high_r    <= tens_r;
      o_low_r     <= units_r;
      o_scale_r   <= decade_r;
      o_freq_r    <= (freq_r == '0) ? FREQ_W'(1) : freq_r;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.changed         = o_changed_r;
  assign out_res.active_menu     = o_menu_r;
  assign out_res.cursor_position = o_cursor_r;
  assign out_res.waveform_choice = o_wave_r;
  assign out_res.high_digit      = o_high_r;
  assign out_res.low_digit       = o_low_r;
  assign out_res.scale_exponent  = o_scale_r;
  assign out_res.frequency_hz    = o_freq_r;

endmodule

@@ hdl/rmfe_alu.sv @@
// Shared arithmetic unit: wrapping counter step and multiply-by-ten accumulate.
// Depends on rmfe_pkg.
module rmfe_alu
  import rmfe_pkg::*;
(
  input  op_t               op,
  input  logic [FREQ_W-1:0] a,
  input  logic [3:0]        b,
  input  logic [3:0]        modulus,
  input  logic              down,
  output logic [FREQ_W-1:0] y
);

  logic [3:0] a_low;
  logic [3:0] top_val;
  logic [3:0] step_val;

  assign a_low   = a[3:0];
  assign top_val = modulus - 4'd1;

  // Wrap one step inside 0..modulus-1
  always_comb begin
    if (down) begin
      step_val = (a_low == 4'd0) ? top_val : a_low - 4'd1;
    end else begin
      step_val = (a_low == top_val) ? 4'd0 : a_low + 4'd1;
    end
  end

  // Select operation; times ten as two shifts and an add
  always_comb begin
    case (op)
      OP_STEP:  y = {{(FREQ_W-4){1'b0}}, step_val};
      OP_MAC10: y = (a << 3) + (a << 1) + {{(FREQ_W-4){1'b0}}, b};
      default:  y = '0;
    endcase
  end

endmodule

@@ hdl/rmfe_seq.sv @@
// Sequencer of the rotary menu frequency editor: tick loop, press, decade loop.
// Depends on rmfe_pkg.
module rmfe_seq
  import rmfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              rot,
  input  logic              press,
  input  logic signed [7:0] ticks,
  input  logic [2:0]        decade,
  input  logic              out_free,
  output ctrl_t             ctrl
);

  state_t     state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [2:0] loop_r, loop_nxt;
  logic       down_r, down_nxt;
  logic       press_r, press_nxt;
  logic       chg_r, chg_nxt;
  logic       first_r, first_nxt;
  logic [7:0] mag;

  // Tick magnitude; the most negative count gives 128
  assign mag      = ticks[7] ? 8'(-ticks) : 8'(ticks);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    loop_nxt  = loop_r;
    down_nxt  = down_r;
    press_nxt = press_r;
    chg_nxt   = chg_r;
    first_nxt = first_r;
    ctrl      = '0;
    ctrl.step_down  = down_r;
    ctrl.freq_first = first_r;
    ctrl.changed    = chg_r;
    case (state_r)
      ST_IDLE: begin
        // Take a request
        if (in_valid) begin
          press_nxt = press;
          chg_nxt   = rot | press;
          down_nxt  = ~ticks[7];
          cnt_nxt   = mag;
          state_nxt = (rot && mag != 8'd0) ? ST_STEP : ST_PRESS;
        end
      end
      ST_STEP: begin
        // Advance one tick per cycle
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          state_nxt = ST_PRESS;
        end
      end
      ST_PRESS: begin
        // Apply the press and seed the frequency loop
        ctrl.press     = press_r;
        ctrl.freq_load = 1'b1;
        loop_nxt       = decade + 3'd1;
        first_nxt      = 1'b1;
        state_nxt      = ST_FREQ;
      end
      ST_FREQ: begin
        // One decade per cycle
        ctrl.freq_mac = 1'b1;
        first_nxt     = 1'b0;
        loop_nxt      = loop_r - 3'd1;
        if (loop_r == 3'd1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the result register is free
        if (out_free) begin
          ctrl.deliver = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    loop_r  <= loop_nxt;
    down_r  <= down_nxt;
    press_r <= press_nxt;
    chg_r   <= chg_nxt;
    first_r <= first_nxt;
  end

endmodule

@@ hdl/rmfe_chk.sv @@
// Port-level checker for the rotary menu frequency editor, with its bind.
// Depends on rotary_menu_frequency_editor_core and the rmfe channel interfaces.
module rmfe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  active_menu,
  input logic [3:0]  high_digit,
  input logic [3:0]  low_digit,
  input logic [2:0]  scale_exponent,
  input logic [26:0] frequency_hz
);

  // One request at a time: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while the previous one is in work");

  // A stalled result holds its frequency
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(frequency_hz)))
    else $error("stalled result changed");

  // Digits and scale stay in their wrap ranges, menu code is legal
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (high_digit <= 4'd9 && low_digit <= 4'd9 &&
                   scale_exponent <= 3'd6 && active_menu <= 3'd4))
    else $error("result field out of range");

  // Frequency never zero and never above 99 MHz
  a_freq_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frequency_hz != 27'd0 && frequency_hz <= 27'd99000000))
    else $error("frequency out of range");

endmodule

bind rotary_menu_frequency_editor_core rmfe_chk u_rmfe_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .active_menu    (out_res.active_menu),
  .high_digit     (out_res.high_digit),
  .low_digit      (out_res.low_digit),
  .scale_exponent (out_res.scale_exponent),
  .frequency_hz   (out_res.frequency_hz)
);
